/* sv/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge once reset has been released.
`define CRB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("connection supervisor check failed");

// Check on every clock edge, reset cycles included.
`define CRB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("connection supervisor reset check failed");

`endif

/* sv/crb_pkg.sv */
package crb_pkg;

  localparam int DELAY_BITS = 24;

  typedef enum logic [2:0] {
    PH_OFF        = 3'd0,
    PH_CONNECTING = 3'd1,
    PH_CONN0      = 3'd2,
    PH_CONN1      = 3'd3,
    PH_CONN2      = 3'd4,
    PH_CONN3      = 3'd5,
    PH_RETRY      = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    KIND_TICK       = 3'd0,
    KIND_CONNECT    = 3'd1,
    KIND_DISCONNECT = 3'd2,
    KIND_RECONNECT  = 3'd3,
    KIND_CLEAR      = 3'd4,
    KIND_ENTER      = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    CFG_TIMEOUT      = 2'd0,
    CFG_MAX_ATTEMPTS = 2'd1,
    CFG_BASE_DELAY   = 2'd2,
    CFG_MAX_DELAY    = 2'd3
  } cfg_idx_t;

  localparam logic [2:0] REASON_NONE    = 3'd0;
  localparam logic [2:0] REASON_TIMEOUT = 3'd1;
  localparam logic [7:0] ATTEMPTS_SAT   = 8'hFF;

  localparam logic [23:0] TIMEOUT_RST      = 24'd30000;
  localparam logic [7:0]  MAX_ATTEMPTS_RST = 8'd5;
  localparam logic [23:0] BASE_DELAY_RST   = 24'd1000;
  localparam logic [23:0] MAX_DELAY_RST    = 24'd30000;

  typedef struct packed {
    logic [23:0] timeout_ms;
    logic [7:0]  max_attempts;
    logic [23:0] base_delay_ms;
    logic [23:0] max_delay_ms;
  } cfg_t;

  // Fixed-width part of the supervisor state.
  typedef struct packed {
    phase_t      phase;
    logic [7:0]  attempts;
    logic [2:0]  reason;
    logic [15:0] saved_port;
    logic        host_known;
  } ctl_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  phase;
    logic        is_connected;
    logic [31:0] uptime_ms;
    logic [2:0]  last_reason;
    logic        disconnect_event;
    logic        attempt_event;
    logic [7:0]  attempt_count;
    logic [23:0] current_delay_ms;
  } res_t;

endpackage

/* sv/crb_delay.sv */
module crb_delay
  import crb_pkg::*;
(
  input  logic [7:0]            attempts,
  input  logic [DELAY_BITS-1:0] base_delay_ms,
  input  logic [DELAY_BITS-1:0] max_delay_ms,
  output logic [DELAY_BITS-1:0] delay_ms
);

  localparam int WIDE = 2 * DELAY_BITS;

  logic [7:0]      shift_amt;
  logic [WIDE-1:0] shifted;

  assign shift_amt = attempts - 8'd1;
  assign shifted   = {{DELAY_BITS{1'b0}}, base_delay_ms} << shift_amt[4:0];

  always_comb begin
    if (attempts == 8'd0) begin
      delay_ms = base_delay_ms;
    end else if (base_delay_ms == '0) begin
      delay_ms = '0;
    end else if (shift_amt >= 8'(DELAY_BITS)) begin
      delay_ms = max_delay_ms;
    end else if (shifted < {{DELAY_BITS{1'b0}}, max_delay_ms}) begin
      delay_ms = shifted[DELAY_BITS-1:0];
    end else begin
      delay_ms = max_delay_ms;
    end
  end

endmodule

/* sv/crb_step.sv */
module crb_step
  import crb_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic [2:0]           kind,
  input  logic [15:0]          tick_ms,
  input  logic [15:0]          port_number,
  input  logic                 host_present,
  input  logic [2:0]           reason_code,
  input  logic [1:0]           link_phase,
  input  cfg_t                 cfg,
  input  ctl_t                 ctl,
  input  logic [TIME_BITS-1:0] connect_elapsed,
  input  logic [TIME_BITS-1:0] uptime,
  input  logic [TIME_BITS-1:0] retry_timer,
  output ctl_t                 ctl_nxt,
  output logic [TIME_BITS-1:0] connect_elapsed_nxt,
  output logic [TIME_BITS-1:0] uptime_nxt,
  output logic [TIME_BITS-1:0] retry_timer_nxt,
  output res_t                 res
);

  localparam int SW = TIME_BITS + 1;

  kind_t                 kind_e;
  phase_t                phase_nxt;
  logic [SW-1:0]         conn_sum, up_sum, retry_sum;
  logic [TIME_BITS-1:0]  conn_sat, up_sat, retry_sat;
  logic [DELAY_BITS-1:0] delay_now, delay_nxt;
  logic                  timeout_hit, fire, give_up, reconnect_ok, open_ok;
  logic [7:0]            attempts_inc;
  logic                  acc, dev, aev, conn_nxt;
  logic [63:0]           up_wide;

  assign kind_e = kind_t'(kind);

  // Saturating timer adds: a carry out pins the timer at its ceiling.
  assign conn_sum  = {1'b0, connect_elapsed} + SW'(tick_ms);
  assign up_sum    = {1'b0, uptime} + SW'(tick_ms);
  assign retry_sum = {1'b0, retry_timer} + SW'(tick_ms);
  assign conn_sat  = conn_sum[TIME_BITS]  ? '1 : conn_sum[TIME_BITS-1:0];
  assign up_sat    = up_sum[TIME_BITS]    ? '1 : up_sum[TIME_BITS-1:0];
  assign retry_sat = retry_sum[TIME_BITS] ? '1 : retry_sum[TIME_BITS-1:0];

  crb_delay u_delay_now (
    .attempts      (ctl.attempts),
    .base_delay_ms (cfg.base_delay_ms),
    .max_delay_ms  (cfg.max_delay_ms),
    .delay_ms      (delay_now)
  );

  crb_delay u_delay_nxt (
    .attempts      (ctl_nxt.attempts),
    .base_delay_ms (cfg.base_delay_ms),
    .max_delay_ms  (cfg.max_delay_ms),
    .delay_ms      (delay_nxt)
  );

  assign timeout_hit  = 64'(conn_sat) >= 64'(cfg.timeout_ms);
  assign fire         = 64'(retry_sat) >= 64'(delay_now);
  assign give_up      = ctl.attempts >= cfg.max_attempts;
  assign attempts_inc = (ctl.attempts == ATTEMPTS_SAT) ? ctl.attempts : ctl.attempts + 8'd1;
  assign open_ok      = (ctl.phase == PH_OFF) || (ctl.phase == PH_RETRY);
  assign reconnect_ok = (ctl.phase == PH_OFF) && ctl.host_known && (ctl.saved_port != 16'd0);

  // Next phase.
  always_comb begin
    phase_nxt = ctl.phase;
    case (kind_e)
      KIND_TICK: begin
        if (ctl.phase == PH_CONNECTING && timeout_hit) begin
          phase_nxt = PH_OFF;
        end else if (ctl.phase == PH_RETRY && fire) begin
          phase_nxt = give_up ? PH_OFF : PH_CONNECTING;
        end
      end
      KIND_CONNECT: begin
        if (open_ok) phase_nxt = PH_CONNECTING;
      end
      KIND_DISCONNECT: phase_nxt = PH_OFF;
      KIND_RECONNECT: begin
        if (reconnect_ok) phase_nxt = PH_RETRY;
      end
      KIND_CLEAR: phase_nxt = PH_OFF;
      KIND_ENTER: phase_nxt = phase_t'(3'(PH_CONN0) + 3'(link_phase));
      default: phase_nxt = ctl.phase;
    endcase
  end

  // Timers, counters and notifications.
  always_comb begin
    ctl_nxt.phase       = phase_nxt;
    ctl_nxt.attempts    = ctl.attempts;
    ctl_nxt.reason      = ctl.reason;
    ctl_nxt.saved_port  = ctl.saved_port;
    ctl_nxt.host_known  = ctl.host_known;
    connect_elapsed_nxt = connect_elapsed;
    uptime_nxt          = uptime;
    retry_timer_nxt     = retry_timer;
    acc                 = 1'b0;
    dev                 = 1'b0;
    aev                 = 1'b0;
    case (kind_e)
      KIND_TICK: begin
        if (ctl.phase == PH_CONNECTING) begin
          connect_elapsed_nxt = conn_sat;
          if (timeout_hit) begin
            ctl_nxt.reason      = REASON_TIMEOUT;
            uptime_nxt          = '0;
            connect_elapsed_nxt = '0;
            dev                 = 1'b1;
          end
        end else if (ctl.phase inside {[PH_CONN0:PH_CONN3]}) begin
          uptime_nxt = up_sat;
        end else if (ctl.phase == PH_RETRY) begin
          retry_timer_nxt = retry_sat;
          if (fire) begin
            retry_timer_nxt     = '0;
            ctl_nxt.attempts    = attempts_inc;
            aev                 = 1'b1;
            connect_elapsed_nxt = '0;
            if (give_up) begin
              ctl_nxt.reason = REASON_TIMEOUT;
              uptime_nxt     = '0;
              dev            = 1'b1;
            end
          end
        end
      end
      KIND_CONNECT: begin
        if (open_ok) begin
          ctl_nxt.saved_port  = port_number;
          ctl_nxt.host_known  = host_present;
          connect_elapsed_nxt = '0;
          ctl_nxt.reason      = REASON_NONE;
          acc                 = 1'b1;
        end
      end
      KIND_DISCONNECT: begin
        if (ctl.phase != PH_OFF) begin
          ctl_nxt.reason      = reason_code;
          uptime_nxt          = '0;
          connect_elapsed_nxt = '0;
          dev                 = 1'b1;
        end
      end
      KIND_RECONNECT: begin
        if (reconnect_ok) begin
          ctl_nxt.attempts = '0;
          retry_timer_nxt  = '0;
          acc              = 1'b1;
        end
      end
      KIND_CLEAR: begin
        ctl_nxt.attempts    = '0;
        ctl_nxt.reason      = REASON_NONE;
        ctl_nxt.saved_port  = '0;
        ctl_nxt.host_known  = 1'b0;
        connect_elapsed_nxt = '0;
        uptime_nxt          = '0;
        retry_timer_nxt     = '0;
      end
      default: begin
      end
    endcase
  end

  // Result as seen after the step.
  assign conn_nxt = ctl_nxt.phase inside {[PH_CONN0:PH_CONN3]};
  assign up_wide  = 64'(uptime_nxt);

  always_comb begin
    res.accepted         = acc;
    res.phase            = ctl_nxt.phase;
    res.is_connected     = conn_nxt;
    res.uptime_ms        = '0;
    if (conn_nxt) begin
      res.uptime_ms = (up_wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : up_wide[31:0];
    end
    res.last_reason      = ctl_nxt.reason;
    res.disconnect_event = dev;
    res.attempt_event    = aev;
    res.attempt_count    = ctl_nxt.attempts;
    res.current_delay_ms = delay_nxt;
  end

endmodule

/* sv/connection_retry_backoff_fsm.sv */
// Connection supervisor with exponential-backoff retries.
// Input channel (in_valid/in_ready): one request per event - tick of in_tick_ms
// milliseconds, connect, disconnect with a reason, reconnect, clear, or entry
// into a connected link phase. Every request yields exactly one result on the
// output channel (out_valid/out_ready) reporting the phase, uptime, last
// disconnect reason, notifications and the retry delay for the current count.
// Configuration (cfg_we/cfg_index/cfg_wdata) writes timeout, attempt limit, base
// delay or delay cap, one per write; write only while no request is open.
// A request accepted into the input register is stepped through the supervisor
// logic from that register, and its result is captured in the output register
// as soon as the result slot is free or being emptied.
// Throughput: one request per cycle while results are taken; each state update
// is one pass of saturating adds, compares and two capped 24-bit shifts.
// Reset (rst_n low, synchronous) empties both stages, clears the state to the
// disconnected phase and reloads the default register values.
// When the receiver stalls, the result holds in the output register, one more
// request waits in the input register, and in_ready drops until out_ready.
module connection_retry_backoff_fsm
  import crb_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_tick_ms,
  input  logic [15:0] in_port_number,
  input  logic        in_host_present,
  input  logic [2:0]  in_reason_code,
  input  logic [1:0]  in_link_phase,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic [2:0]  out_phase,
  output logic        out_is_connected,
  output logic [31:0] out_uptime_ms,
  output logic [2:0]  out_last_reason,
  output logic        out_disconnect_event,
  output logic        out_attempt_event,
  output logic [7:0]  out_attempt_count,
  output logic [23:0] out_current_delay_ms,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  // Input stage.
  logic        in_valid_r;
  logic [2:0]  kind_r;
  logic [15:0] tick_r, port_r;
  logic        host_r;
  logic [2:0]  reason_r;
  logic [1:0]  lphase_r;

  // Supervisor state.
  cfg_t                 cfg_r;
  ctl_t                 ctl_r, ctl_nxt;
  logic [TIME_BITS-1:0] conn_r, conn_nxt;
  logic [TIME_BITS-1:0] uptime_r, uptime_nxt;
  logic [TIME_BITS-1:0] retry_r, retry_nxt;

  // Output stage.
  logic out_valid_r;
  res_t res_r, res_nxt;

  logic advance;

  // Step the held request whenever the result slot is free or being emptied.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  // Payload needs no reset; load only on an accepted request.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r   <= in_kind;
      tick_r   <= in_tick_ms;
      port_r   <= in_port_number;
      host_r   <= in_host_present;
      reason_r <= in_reason_code;
      lphase_r <= in_link_phase;
    end
  end

  // Configuration registers keep their values across a clear request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ms    <= TIMEOUT_RST;
      cfg_r.max_attempts  <= MAX_ATTEMPTS_RST;
      cfg_r.base_delay_ms <= BASE_DELAY_RST;
      cfg_r.max_delay_ms  <= MAX_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TIMEOUT:      cfg_r.timeout_ms    <= cfg_wdata;
        CFG_MAX_ATTEMPTS: cfg_r.max_attempts  <= cfg_wdata[7:0];
        CFG_BASE_DELAY:   cfg_r.base_delay_ms <= cfg_wdata;
        CFG_MAX_DELAY:    cfg_r.max_delay_ms  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  crb_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .kind                (kind_r),
    .tick_ms             (tick_r),
    .port_number         (port_r),
    .host_present        (host_r),
    .reason_code         (reason_r),
    .link_phase          (lphase_r),
    .cfg                 (cfg_r),
    .ctl                 (ctl_r),
    .connect_elapsed     (conn_r),
    .uptime              (uptime_r),
    .retry_timer         (retry_r),
    .ctl_nxt             (ctl_nxt),
    .connect_elapsed_nxt (conn_nxt),
    .uptime_nxt          (uptime_nxt),
    .retry_timer_nxt     (retry_nxt),
    .res                 (res_nxt)
  );

  // Commit the step together with its result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.phase      <= PH_OFF;
      ctl_r.attempts   <= '0;
      ctl_r.reason     <= REASON_NONE;
      ctl_r.saved_port <= '0;
      ctl_r.host_known <= 1'b0;
      conn_r           <= '0;
      uptime_r         <= '0;
      retry_r          <= '0;
    end else if (advance) begin
      ctl_r    <= ctl_nxt;
      conn_r   <= conn_nxt;
      uptime_r <= uptime_nxt;
      retry_r  <= retry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_accepted         = res_r.accepted;
  assign out_phase            = res_r.phase;
  assign out_is_connected     = res_r.is_connected;
  assign out_uptime_ms        = res_r.uptime_ms;
  assign out_last_reason      = res_r.last_reason;
  assign out_disconnect_event = res_r.disconnect_event;
  assign out_attempt_event    = res_r.attempt_event;
  assign out_attempt_count    = res_r.attempt_count;
  assign out_current_delay_ms = res_r.current_delay_ms;

endmodule

/* sv/crb_checker.sv */
`include "assert_macros.svh"

module crb_props
  import crb_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_phase,
  input logic        out_is_connected,
  input logic [31:0] out_uptime_ms,
  input logic        out_disconnect_event
);

  logic conn_ph;

  assign conn_ph = out_phase inside {[PH_CONN0:PH_CONN3]};

  // Reset empties the result stage.
  `CRB_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)

  // A stalled result stays offered.
  `CRB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)

  // Connected flag agrees with the reported phase.
  `CRB_ASSERT(a_conn_flag, out_valid |-> out_is_connected == conn_ph)

  // Uptime reads zero outside the connected phases.
  `CRB_ASSERT(a_uptime_zero, out_valid && !out_is_connected |-> out_uptime_ms == 32'd0)

  // A disconnect always lands in the disconnected phase.
  `CRB_ASSERT(a_drop_phase, out_valid && out_disconnect_event |-> out_phase == PH_OFF)

endmodule

bind connection_retry_backoff_fsm crb_props u_crb_props (.*);
